@@ rtl/cfd_pkg.sv @@
package cfd_pkg;

    localparam logic [7:0]  HEAD_BYTE        = 8'h7D;
    localparam logic [7:0]  TAIL_BYTE        = 8'h0D;
    localparam logic [15:0] MAX_LEN_RESET    = 16'd1024;

    // Frame phase of the deframer
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_SUM_LO = 3'd3,
        PH_SUM_HI = 3'd4,
        PH_BODY   = 3'd5,
        PH_TAIL   = 3'd6
    } phase_t;

    // Frame status codes
    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_OK    = 2'd1,
        ST_CKERR = 2'd2,
        ST_FRERR = 2'd3
    } status_t;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_payload;
        logic       frame_done;
        status_t    frame_status;
    } result_t;

endpackage

@@ rtl/cfd_core.sv @@
module cfd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic [15:0]      max_len,
    output cfd_pkg::result_t res
);
    import cfd_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic [15:0] len_reg,     len_next;
    logic [15:0] seen_reg,    seen_next;
    logic [15:0] run_sum_reg, run_sum_next;
    logic [15:0] rcv_sum_reg, rcv_sum_next;
    logic [15:0] len_full;
    logic [15:0] seen_inc;

    assign len_full = {in_byte, len_reg[7:0]};
    assign seen_inc = seen_reg + 16'd1;

    // Decode one byte against the current phase
    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        seen_next    = seen_reg;
        run_sum_next = run_sum_reg;
        rcv_sum_next = rcv_sum_reg;
        res.out_byte     = 8'd0;
        res.is_payload   = 1'b0;
        res.frame_done   = 1'b0;
        res.frame_status = ST_NONE;

        case (phase_reg)
            PH_HUNT:
            begin
                if (in_byte == HEAD_BYTE)
                begin
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                len_next   = {8'd0, in_byte};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_next = len_full;
                if (len_full > max_len)
                begin
                    res.frame_done   = 1'b1;
                    res.frame_status = ST_FRERR;
                    phase_next       = PH_HUNT;
                end
                else
                begin
                    run_sum_next = len_full;
                    seen_next    = 16'd0;
                    phase_next   = PH_SUM_LO;
                end
            end
            PH_SUM_LO:
            begin
                rcv_sum_next = {8'd0, in_byte};
                phase_next   = PH_SUM_HI;
            end
            PH_SUM_HI:
            begin
                rcv_sum_next = {in_byte, rcv_sum_reg[7:0]};
                phase_next   = (len_reg == 16'd0) ? PH_TAIL : PH_BODY;
            end
            PH_BODY:
            begin
                res.out_byte   = in_byte;
                res.is_payload = 1'b1;
                run_sum_next   = run_sum_reg + {8'd0, in_byte};
                seen_next      = seen_inc;
                if (seen_inc >= len_reg)
                begin
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                res.frame_done = 1'b1;
                if (in_byte != TAIL_BYTE)
                begin
                    res.frame_status = ST_FRERR;
                end
                else if (run_sum_reg != rcv_sum_reg)
                begin
                    res.frame_status = ST_CKERR;
                end
                else
                begin
                    res.frame_status = ST_OK;
                end
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Advance the frame state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            len_reg     <= 16'd0;
            seen_reg    <= 16'd0;
            run_sum_reg <= 16'd0;
            rcv_sum_reg <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            seen_reg    <= seen_next;
            run_sum_reg <= run_sum_next;
            rcv_sum_reg <= rcv_sum_next;
        end
    end

endmodule

@@ rtl/checksum_frame_decoder.sv @@
// Byte-stream deframer: drops bytes until head 0x7D, then reads a little-endian
// 16-bit length and checksum, passes each payload byte with is_payload set, and
// at the tail position reports ok, checksum mismatch or framing error (wrong
// tail 0x0D, or length above max_payload_len, which aborts on the length's high
// byte). Every input byte gives exactly one result. One byte is taken per clock
// while in_ready is high: the frame decode is a single compare, 16-bit add and
// phase step between the input and the output register, so throughput is one
// byte per cycle while the skid register is empty. The two-entry output stage
// (output register plus skid register) registers each result and takes one
// more byte while the output stalls; input ready then stays low until the skid
// register drains into the output register. max_payload_len is written on the
// cfg channel, which is always ready, and should change only while no frame is
// in flight.
module checksum_frame_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 is_payload,
    output logic                 frame_done,
    output cfd_pkg::status_t     frame_status
);
    import cfd_pkg::*;

    logic [15:0] max_len_reg;
    logic        accept;
    logic        out_fire;
    result_t     res;
    result_t     out_reg;
    result_t     skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    // Hold the length limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            max_len_reg <= cfg_data;
        end
    end

    cfd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .max_len (max_len_reg),
        .res     (res)
    );

    // Output register and skid stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Load results: skid drains first, new result parks in skid on stall
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_reg.out_byte;
    assign is_payload   = out_reg.is_payload;
    assign frame_done   = out_reg.frame_done;
    assign frame_status = out_reg.frame_status;

endmodule
